// ===== rtl/bsa_pkg.sv =====
package bsa_pkg;

  localparam int MAX_ORDER_DEF = 10;
  localparam int ORD_W         = 4;
  localparam int SEG_W         = 10;
  localparam int WORD_W        = 32;
  localparam int LW            = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_FAIL  = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [ORD_W-1:0] block_order;
    logic [SEG_W-1:0] free_segment;
  } in_t;

  typedef struct packed {
    logic [SEG_W-1:0] alloc_segment;
    logic             status;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_SP_RD, S_SP_WR, S_F_RD, S_F_CHK, S_DONE
  } state_t;

  function automatic int order_words(int top_ord, int o);
    int cnt;
    begin
      cnt = 1 << (top_ord - o);
      order_words = (cnt >= WORD_W) ? (cnt >> LW) : 1;
    end
  endfunction

  function automatic int word_base(int top_ord, int o);
    int acc;
    begin
      acc = 0;
      for (int k = 0; k < o; k++) acc += order_words(top_ord, k);
      word_base = acc;
    end
  endfunction

  function automatic logic [WORD_W-1:0] order_mask(int top_ord, int o);
    int cnt;
    logic [WORD_W-1:0] m;
    begin
      cnt = 1 << (top_ord - o);
      m = '0;
      for (int i = 0; i < WORD_W; i++) m[i] = (i < cnt);
      order_mask = m;
    end
  endfunction

endpackage

// ===== rtl/bsa_ram.sv =====
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/buddy_segment_allocator_top.sv =====
// An allocate reads and checks each bitmap word scanned (S_A_RD, S_A_CHK) and reads and
// writes once per split (S_SP_RD, S_SP_WR); a free reads and checks each order visited
// (S_F_RD, S_F_CHK). Each ends in the result state S_DONE; a bad order goes straight there.
// The block returns to idle after every result before the next transfer. Throughput is
// one item at a time, set by the bitmap memory read-modify-write; the receiver cannot stall.
// After reset a clearing pass writes every bitmap word, one per cycle, while busy stays high.
module buddy_segment_allocator_top #(
  parameter int MAX_ORDER = bsa_pkg::MAX_ORDER_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bsa_pkg::in_t  in_data,
  output logic          out_valid,
  output bsa_pkg::out_t out_data
);
  import bsa_pkg::*;

  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int IDX_W = MAX_ORDER + LW;
  localparam int WW    = MAX_ORDER;
  localparam int DEPTH = word_base(MAX_ORDER, MAX_ORDER) + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [AW-1:0]     base_w [0:MAX_ORDER];
  logic [WW-1:0]     last_w [0:MAX_ORDER];
  logic [WORD_W-1:0] mask_w [0:MAX_ORDER];

  for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_ord
    assign base_w[g] = AW'(word_base(MAX_ORDER, g));
    assign last_w[g] = WW'(order_words(MAX_ORDER, g) - 1);
    assign mask_w[g] = order_mask(MAX_ORDER, g);
  end

  state_t            state_r, state_nxt;
  logic [OW-1:0]     o_r, o_nxt, ord_r, ord_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WW-1:0]     w_r, w_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  out_t              res_r, res_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata, masked;
  logic [OW-1:0]     rd_o;
  logic [IDX_W-1:0]  rd_idx, bud;
  logic [WW-1:0]     rd_word, wr_word;
  logic [LW-1:0]     lb;

  bsa_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign masked = rdata & mask_w[o_r];
  assign bud    = idx_r ^ IDX_W'(1);

  always_comb begin
    lb = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (masked[i]) lb = LW'(i);
    end
  end

  always_comb begin
    state_nxt = state_r;
    o_nxt     = o_r;
    ord_nxt   = ord_r;
    idx_nxt   = idx_r;
    w_nxt     = w_r;
    clr_nxt   = clr_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          res_nxt   = '{alloc_segment: '0, status: ST_FAIL};
          ord_nxt   = OW'(in_data.block_order);
          o_nxt     = OW'(in_data.block_order);
          w_nxt     = '0;
          idx_nxt   = (IDX_W'(in_data.free_segment) >> in_data.block_order)
                      & ~({IDX_W{1'b1}} << (MAX_ORDER - int'(in_data.block_order)));
          if (int'(in_data.block_order) > MAX_ORDER) state_nxt = S_DONE;
          else if (in_data.operation == OP_ALLOC) state_nxt = S_A_RD;
          else state_nxt = S_F_RD;
        end
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (|masked) begin
          idx_nxt = {w_r, lb};
          if (o_r > ord_r) begin
            state_nxt = S_SP_RD;
          end else begin
            res_nxt   = '{alloc_segment: SEG_W'({w_r, lb} << ord_r), status: ST_OK};
            state_nxt = S_DONE;
          end
        end else if (w_r != last_w[o_r]) begin
          w_nxt     = w_r + WW'(1);
          state_nxt = S_A_RD;
        end else if (o_r != OW'(MAX_ORDER)) begin
          w_nxt     = '0;
          o_nxt     = o_r + OW'(1);
          state_nxt = S_A_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SP_RD: begin
        o_nxt     = rd_o;
        idx_nxt   = rd_idx;
        state_nxt = S_SP_WR;
      end
      S_SP_WR: begin
        if (o_r > ord_r) begin
          state_nxt = S_SP_RD;
        end else begin
          res_nxt   = '{alloc_segment: SEG_W'(idx_r << ord_r), status: ST_OK};
          state_nxt = S_DONE;
        end
      end
      S_F_RD: state_nxt = S_F_CHK;
      S_F_CHK: begin
        if (o_r != OW'(MAX_ORDER) && rdata[bud[LW-1:0]]) begin
          idx_nxt   = idx_r >> 1;
          o_nxt     = o_r + OW'(1);
          state_nxt = S_F_RD;
        end else begin
          res_nxt   = '{alloc_segment: '0, status: ST_OK};
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_o    = (state_r == S_SP_RD) ? o_r - OW'(1) : o_r;
    rd_idx  = (state_r == S_SP_RD) ? idx_r << 1 : idx_r;
    rd_word = (state_r == S_A_RD) ? w_r : rd_idx[IDX_W-1:LW];
    raddr   = base_w[rd_o] + AW'(rd_word);
    wr_word = (state_r == S_A_CHK) ? w_r : idx_r[IDX_W-1:LW];
    waddr   = base_w[o_r] + AW'(wr_word);
    we      = 1'b0;
    wdata   = rdata;
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = (clr_r == base_w[MAX_ORDER]) ? WORD_W'(1) : '0;
      end
      S_A_CHK: begin
        we    = |masked;
        wdata = rdata & ~(WORD_W'(1) << lb);
      end
      S_SP_WR: begin
        we    = 1'b1;
        wdata = rdata | (WORD_W'(1) << (idx_r[LW-1:0] | LW'(1)));
      end
      S_F_CHK: begin
        we = 1'b1;
        if (o_r != OW'(MAX_ORDER) && rdata[bud[LW-1:0]]) begin
          wdata = rdata & ~(WORD_W'(1) << bud[LW-1:0]);
        end else begin
          wdata = rdata | (WORD_W'(1) << idx_r[LW-1:0]);
        end
      end
      default: we = 1'b0;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    o_r   <= o_nxt;
    ord_r <= ord_nxt;
    idx_r <= idx_nxt;
    w_r   <= w_nxt;
    res_r <= res_nxt;
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import bsa_pkg::*;

  localparam int TOP_ORDER = MAX_ORDER_DEF;
  localparam int MAP_BITS = 2 << TOP_ORDER;
  localparam int STALL_LIMIT = 20000;

  class alloc_scoreboard;
    bit free_bits[MAP_BITS];
    out_t pending[$];
    int errors;

    function new();
      errors = 0;
      free_bits[map_addr(TOP_ORDER, 0)] = 1'b1;
    endfunction

    function int map_addr(int o, int idx);
      int cnt;
      cnt = 1 << (TOP_ORDER - o);
      return (MAP_BITS - (2 << (TOP_ORDER - o))) + (idx & (cnt - 1));
    endfunction

    function void note_request(in_t req);
      out_t res;
      int o;
      int idx;
      bit found;
      res.alloc_segment = '0;
      res.status = ST_FAIL;
      found = 1'b0;
      idx = 0;
      o = req.block_order;
      if (req.block_order <= TOP_ORDER) begin
        if (req.operation == OP_ALLOC) begin
          for (o = req.block_order; o <= TOP_ORDER && !found; o++) begin
            for (idx = 0; idx < (1 << (TOP_ORDER - o)); idx++) begin
              if (free_bits[map_addr(o, idx)]) begin
                found = 1'b1;
                break;
              end
            end
            if (found) break;
          end
          if (found) begin
            free_bits[map_addr(o, idx)] = 1'b0;
            while (o > req.block_order) begin
              o--;
              idx = idx << 1;
              free_bits[map_addr(o, idx ^ 1)] = 1'b1;
            end
            res.alloc_segment = SEG_W'(idx << req.block_order);
            res.status = ST_OK;
          end
        end else begin
          idx = (int'(req.free_segment) >> o) & ((1 << (TOP_ORDER - o)) - 1);
          while (o < TOP_ORDER && free_bits[map_addr(o, idx ^ 1)]) begin
            free_bits[map_addr(o, idx ^ 1)] = 1'b0;
            idx = idx >> 1;
            o++;
          end
          free_bits[map_addr(o, idx)] = 1'b1;
          res.status = ST_OK;
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result seg=%0d status=%0d", got.alloc_segment, got.status);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.alloc_segment !== exp.alloc_segment) begin
        $error("alloc_segment expected %0d actual %0d", exp.alloc_segment, got.alloc_segment);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status expected %0d actual %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  int idle_cycles = 0;
  alloc_scoreboard sb = new();
  logic [SEG_W-1:0] owned_seg[$];
  logic [ORD_W-1:0] owned_ord[$];

  always #5 clk = ~clk;

  buddy_segment_allocator_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
    if (rst_n && (out_valid || (start && !busy))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The block is busy in the cycle after a transfer, so start may stay high
  // while the next item is set up; it is dropped only for a gap or a drain.
  task automatic issue(input logic op, input logic [ORD_W-1:0] ord,
                       input logic [SEG_W-1:0] seg, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{operation: op, block_order: ord, free_segment: seg};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(in_data);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic do_alloc(input logic [ORD_W-1:0] ord, input int gap);
    issue(OP_ALLOC, ord, SEG_W'($urandom), gap);
    if (sb.pending[$].status == ST_OK) begin
      owned_seg.push_back(sb.pending[$].alloc_segment);
      owned_ord.push_back(ord);
    end
  endtask

  task automatic do_free_owned(input int gap);
    int k;
    logic [SEG_W-1:0] seg;
    logic [ORD_W-1:0] ord;
    k = $urandom_range(0, owned_seg.size() - 1);
    seg = owned_seg[k];
    ord = owned_ord[k];
    owned_seg.delete(k);
    owned_ord.delete(k);
    issue(OP_FREE, ord, seg, gap);
  endtask

  initial begin
    int gap;
    int r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    do_alloc(4'd15, 0);
    issue(OP_FREE, 4'd15, 10'h3ff, 0);
    do_alloc(4'd10, 0);
    do_alloc(4'd0, 0);
    issue(OP_FREE, 4'd10, 10'd0, 0);
    for (int i = 0; i < 6; i++) do_alloc(4'd0, 0);
    do_alloc(4'd9, 1);
    do_alloc(4'd8, 0);
    do_alloc(4'd9, 0);
    issue(OP_FREE, 4'd0, 10'h3ff, 2);
    issue(OP_FREE, 4'd3, 10'h2a5, 0);
    issue(OP_FREE, 4'd11, 10'h155, 0);
    drain();
    while (owned_seg.size() != 0) do_free_owned(0);
    issue(OP_FREE, 4'd10, 10'd0, 0);
    drain();
    for (int i = 0; i < 1250; i++) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if ((i / 100) % 3 == 1) gap = 0;
      r = $urandom_range(0, 99);
      if (r < 50) do_alloc(ORD_W'($urandom_range(0, 5) == 0 ? $urandom_range(0, 15) :
                                    $urandom_range(0, 4)), gap);
      else if (r < 92 && owned_seg.size() != 0) do_free_owned(gap);
      else if (r < 97) issue(OP_FREE, ORD_W'($urandom), SEG_W'($urandom), gap);
      else begin
        drain();
        while (owned_seg.size() != 0) do_free_owned(0);
      end
      if (i == 600) drain();
    end
    drain();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
